/* rtl/hcb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg
// shared types, codes and widths of the cone brush height grid
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 12;
  localparam int H_W        = 16;
  localparam int COORD_W    = 16;
  localparam int DIM_W      = 7;
  localparam int SPC_W      = 10;
  localparam int RAD_W      = 16;
  localparam int AMT_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // distance path widths
  localparam int POS_W  = DIM_W + SPC_W;      // sample position and grid extent
  localparam int DIFF_W = POS_W + 1;          // signed offset from the centre
  localparam int SQ_W   = 2 * POS_W;          // one squared offset
  localparam int D2_W   = SQ_W + 1;           // sum of squares
  localparam int ROOT_W = 16;                 // root of the low 32 bits
  localparam int RAD2_W = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 4;
  localparam int QUO_W  = AMT_W;
  localparam int PROD_W = RAD_W + QUO_W;
  localparam int CHG_W  = AMT_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RAISE = 2'd2,
    OP_LOWER = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_W    = 3'd0,
    REG_GRID_H    = 3'd1,
    REG_SPACING_X = 3'd2,
    REG_SPACING_Y = 3'd3,
    REG_RADIUS    = 3'd4,
    REG_AMOUNT    = 3'd5
  } reg_e;

  localparam logic [DIM_W-1:0] GRID_W_RST    = 7'd64;
  localparam logic [DIM_W-1:0] GRID_H_RST    = 7'd64;
  localparam logic [SPC_W-1:0] SPACING_X_RST = 10'd256;
  localparam logic [SPC_W-1:0] SPACING_Y_RST = 10'd256;
  localparam logic [RAD_W-1:0] RADIUS_RST    = 16'd0;
  localparam logic [AMT_W-1:0] AMOUNT_RST    = 15'd0;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_PREP  = 6'b000100,
    ST_ISSUE = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD2_W-1:0] rest;
  } sqrt_st_t;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] rest;
  } div_st_t;

endpackage
`default_nettype wire

/* rtl/hcb_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_in_if
// command channel: one operation per beat
// ----------------------------------------------------------------------------
interface hcb_in_if;
  import hcb_pkg::*;
  logic                      valid;
  logic                      ready;
  op_e                       operation;
  logic [IDX_W-1:0]          sample_index;
  logic signed [H_W-1:0]     sample_value;
  logic [COORD_W-1:0]        center_x;
  logic [COORD_W-1:0]        center_y;
  modport source (output valid, operation, sample_index, sample_value, center_x, center_y,
                  input ready);
  modport sink (input valid, operation, sample_index, sample_value, center_x, center_y,
                output ready);
endinterface
`default_nettype wire

/* rtl/hcb_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_out_if
// result channel: one beat per command
// ----------------------------------------------------------------------------
interface hcb_out_if;
  import hcb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] read_value;
  logic signed [H_W-1:0] highest_height;
  logic signed [H_W-1:0] lowest_height;
  modport source (output valid, read_value, highest_height, lowest_height, input ready);
  modport sink (input valid, read_value, highest_height, lowest_height, output ready);
endinterface
`default_nettype wire

/* rtl/hcb_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface hcb_cfg_if;
  import hcb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/hcb_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_store
// height sample memory, one write and one registered read port
// ----------------------------------------------------------------------------
module hcb_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic signed [hcb_pkg::H_W-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic signed [hcb_pkg::H_W-1:0] rdata_o
);
  import hcb_pkg::*;

  logic [H_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= $signed(mem[raddr_i]);
    end
  end

endmodule
`default_nettype wire

/* rtl/hcb_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module hcb_sqrt #(
  parameter int TAG_W = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [hcb_pkg::RAD2_W-1:0]   value_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic                         valid_o,
  output logic [hcb_pkg::ROOT_W-1:0]   root_o,
  output logic [TAG_W-1:0]             tag_o
);
  import hcb_pkg::*;

  localparam int N = ROOT_W;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t          n;
    logic [SREM_W-1:0] r2;
    logic [SREM_W-1:0] trial;
    r2    = {s.rem[SREM_W-3:0], s.rest[RAD2_W-1 -: 2]};
    trial = SREM_W'({s.root, 2'b01});
    if (r2 >= trial) begin
      n.rem  = r2 - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = r2;
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    n.rest = {s.rest[RAD2_W-3:0], 2'b00};
    return n;
  endfunction

  logic       v_q   [N];
  sqrt_st_t   st_q  [N];
  sqrt_st_t   st_d  [N];
  logic [TAG_W-1:0] tag_q [N];

  always_comb begin
    st_d[0] = sqrt_step('{rem: '0, root: '0, rest: value_i});
    for (int k = 1; k < N; k++) begin
      st_d[k] = sqrt_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= st_d[0];
    tag_q[0] <= tag_i;
    for (int k = 1; k < N; k++) begin
      st_q[k]  <= st_d[k];
      tag_q[k] <= tag_q[k-1];
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = st_q[N-1].root;
  assign tag_o   = tag_q[N-1];

endmodule
`default_nettype wire

/* rtl/hcb_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module hcb_div #(
  parameter int TAG_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [hcb_pkg::PROD_W-1:0]  dividend_i,
  input  logic [hcb_pkg::RAD_W-1:0]   divisor_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [hcb_pkg::QUO_W-1:0]   quot_o,
  output logic [TAG_W-1:0]            tag_o
);
  import hcb_pkg::*;

  localparam int N = QUO_W;

  // quotient is known to fit QUO_W bits, so the top of the dividend starts as remainder
  function automatic div_st_t div_step(div_st_t s, logic [RAD_W-1:0] dv);
    div_st_t          n;
    logic [RAD_W:0]   r2;
    logic [RAD_W:0]   diff;
    r2   = {s.rem, s.rest[QUO_W-1]};
    diff = r2 - {1'b0, dv};
    if (r2 >= {1'b0, dv}) begin
      n.rem = diff[RAD_W-1:0];
      n.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.rem = r2[RAD_W-1:0];
      n.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    n.rest = {s.rest[QUO_W-2:0], 1'b0};
    return n;
  endfunction

  logic             v_q   [N];
  div_st_t          st_q  [N];
  div_st_t          st_d  [N];
  logic [TAG_W-1:0] tag_q [N];

  always_comb begin
    st_d[0] = div_step('{rem: dividend_i[PROD_W-1 -: RAD_W], quo: '0,
                         rest: dividend_i[QUO_W-1:0]}, divisor_i);
    for (int k = 1; k < N; k++) begin
      st_d[k] = div_step(st_q[k-1], divisor_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= st_d[0];
    tag_q[0] <= tag_i;
    for (int k = 1; k < N; k++) begin
      st_q[k]  <= st_d[k];
      tag_q[k] <= tag_q[k-1];
    end
  end

  assign valid_o = v_q[N-1];
  assign quot_o  = st_q[N-1].quo;
  assign tag_o   = tag_q[N-1];

endmodule
`default_nettype wire

/* rtl/heightmap_cone_brush_unit.sv */
// write, and raise or lower with the brush off: idle, done; read: idle, read, done
// brush: prep, issue, drain, done over W*H samples; the sample walk reads the store once per cycle and
//   the square, root, divide and write-back pipeline adds its fill and drain
// one command in flight at a time; a finished result may wait in the output register
// reset: config to defaults, tracked heights to zero, store contents undefined
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_cone_brush_unit
// height grid with single-sample access and a cone raise or lower brush
// ----------------------------------------------------------------------------
module heightmap_cone_brush_unit #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcb_cfg_if.sink   cfg_i,
  hcb_in_if.sink    in_i,
  hcb_out_if.source out_o
);
  import hcb_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IXW   = (AW > IDX_W) ? AW : IDX_W;
  // grid size registers are 7 bits wide, so the clamp never goes above 127
  localparam logic [DIM_W-1:0] MAXC = (MAX_COLUMNS > 127) ? 7'd127 : DIM_W'(MAX_COLUMNS);
  localparam logic [DIM_W-1:0] MAXR = (MAX_ROWS > 127) ? 7'd127 : DIM_W'(MAX_ROWS);

  // tag carried alongside each sample through the arithmetic pipeline
  typedef struct packed {
    logic [AW-1:0]  addr;
    logic [H_W-1:0] z;
    logic           skip;
    logic           last;
  } tag_t;
  localparam int TAG_W = $bits(tag_t);

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0] grid_w_q, grid_h_q;
  logic [SPC_W-1:0] spc_x_q, spc_y_q;
  logic [RAD_W-1:0] radius_q;
  logic [AMT_W-1:0] amount_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_W_RST;
      grid_h_q <= GRID_H_RST;
      spc_x_q  <= SPACING_X_RST;
      spc_y_q  <= SPACING_Y_RST;
      radius_q <= RADIUS_RST;
      amount_q <= AMOUNT_RST;
    end else if (cfg_i.valid) begin
      case (reg_e'(cfg_i.index))
        REG_GRID_W:    grid_w_q <= cfg_i.data[DIM_W-1:0];
        REG_GRID_H:    grid_h_q <= cfg_i.data[DIM_W-1:0];
        REG_SPACING_X: spc_x_q  <= cfg_i.data[SPC_W-1:0];
        REG_SPACING_Y: spc_y_q  <= cfg_i.data[SPC_W-1:0];
        REG_RADIUS:    radius_q <= cfg_i.data[RAD_W-1:0];
        REG_AMOUNT:    amount_q <= cfg_i.data[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size, clamped to [2, max]
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [2*DIM_W-1:0] wh;

  always_comb begin
    if (grid_w_q < DIM_W'(2))  w_eff = DIM_W'(2);
    else if (grid_w_q > MAXC)  w_eff = MAXC;
    else                       w_eff = grid_w_q;
    if (grid_h_q < DIM_W'(2))  h_eff = DIM_W'(2);
    else if (grid_h_q > MAXR)  h_eff = MAXR;
    else                       h_eff = grid_h_q;
  end

  assign wh = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);

  // ---------------- command decode ----------------
  logic           in_acc;
  logic           idx_ok;
  logic [IXW-1:0] idx_ext;
  logic [AW-1:0]  idx_addr;
  logic           brush_off;

  assign in_acc    = in_i.valid && in_i.ready;
  assign idx_ok    = (2*DIM_W)'(in_i.sample_index) < wh;
  assign idx_ext   = IXW'(in_i.sample_index);
  assign idx_addr  = idx_ext[AW-1:0];
  assign brush_off = (radius_q == '0) || (amount_q == '0);

  // ---------------- control state ----------------
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  logic [POS_W-1:0] ext_x_q, ext_y_q;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic [POS_W-1:0] px_q, py_q;
  logic             lower_q;
  logic             rd_ok_q;
  logic signed [H_W-1:0] rd_val_q;

  // sample walk
  logic [DIM_W-1:0] col_q, row_q;
  logic [POS_W-1:0] sx_q, sy_q;
  logic [AW-1:0]    addr_q;
  logic             last_issue;

  // write-back stage
  logic                  vf_q, keepf_q, lastf_q;
  logic signed [H_W-1:0] af_q;
  logic [AW-1:0]         addrf_q;

  logic signed [H_W-1:0] max_q, min_q;

  // store read data, registered inside the memory
  logic signed [H_W-1:0] store_rdata;

  assign out_free   = !out_valid_q || out_o.ready;
  assign last_issue = (col_q == w_eff - DIM_W'(1)) && (row_q == h_eff - DIM_W'(1));
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.operation)
            OP_WRITE: state_d = ST_DONE;
            OP_READ:  state_d = ST_READ;
            default:  state_d = brush_off ? ST_DONE : ST_PREP;
          endcase
        end
      end
      ST_READ:  state_d = ST_DONE;
      ST_PREP:  state_d = ST_ISSUE;
      ST_ISSUE: if (last_issue) state_d = ST_DRAIN;
      ST_DRAIN: if (vf_q && lastf_q) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command payload, extents and the sample walk counters
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rd_ok_q  <= idx_ok;
          rd_val_q <= '0;
          cx_q     <= in_i.center_x;
          cy_q     <= in_i.center_y;
          lower_q  <= (in_i.operation == OP_LOWER);
          ext_x_q  <= POS_W'(w_eff) * POS_W'(spc_x_q);
          ext_y_q  <= POS_W'(h_eff) * POS_W'(spc_y_q);
        end
      end
      ST_READ: begin
        rd_val_q <= rd_ok_q ? store_rdata : '0;
      end
      ST_PREP: begin
        // centre clamped to the grid extent
        px_q   <= (POS_W'(cx_q) > ext_x_q) ? ext_x_q : POS_W'(cx_q);
        py_q   <= (POS_W'(cy_q) > ext_y_q) ? ext_y_q : POS_W'(cy_q);
        col_q  <= '0;
        row_q  <= '0;
        sx_q   <= '0;
        sy_q   <= '0;
        addr_q <= '0;
      end
      ST_ISSUE: begin
        addr_q <= addr_q + AW'(1);
        if (col_q == w_eff - DIM_W'(1)) begin
          col_q <= '0;
          sx_q  <= '0;
          row_q <= row_q + DIM_W'(1);
          sy_q  <= sy_q + POS_W'(spc_y_q);
        end else begin
          col_q <= col_q + DIM_W'(1);
          sx_q  <= sx_q + POS_W'(spc_x_q);
        end
      end
      default: ;
    endcase
  end

  // ---------------- height store ----------------
  logic                  st_we, st_re;
  logic [AW-1:0]         st_waddr, st_raddr;
  logic signed [H_W-1:0] st_wdata;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = addrf_q;
    st_wdata = af_q;
    if (vf_q && keepf_q) begin
      st_we = 1'b1;
    end else if (state_q == ST_IDLE && in_acc && in_i.operation == OP_WRITE && idx_ok) begin
      st_we    = 1'b1;
      st_waddr = idx_addr;
      st_wdata = in_i.sample_value;
    end
    st_re    = 1'b0;
    st_raddr = addr_q;
    if (state_q == ST_ISSUE) begin
      st_re = 1'b1;
    end else if (state_q == ST_IDLE && in_acc && in_i.operation == OP_READ) begin
      st_re    = 1'b1;
      st_raddr = idx_addr;
    end
  end

  hcb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (store_rdata)
  );

  // ---------------- brush pipeline ----------------
  // stage a: offsets from the centre, store read in flight
  logic                     va_q, lasta_q;
  logic signed [DIFF_W-1:0] dxa_q, dya_q;
  logic [AW-1:0]            addra_q;

  // stage b: squared offsets and the sample height
  logic                     vb_q, lastb_q;
  logic [SQ_W-1:0]          sqxb_q, sqyb_q;
  logic [AW-1:0]            addrb_q;
  logic signed [H_W-1:0]    zb_q;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;

  // stage c: squared distance
  logic                     vc_q;
  logic [RAD2_W-1:0]        d2c_q;
  tag_t                     tagc_q;
  logic [D2_W-1:0]          d2_sum;

  // root out and stage d: cone product
  logic                     sq_v;
  logic [ROOT_W-1:0]        sq_root;
  logic [TAG_W-1:0]         sq_tag_raw;
  tag_t                     sq_tag;
  logic                     vd_q;
  logic [PROD_W-1:0]        prodd_q;
  tag_t                     tagd_q;

  // quotient out
  logic                     dv_v;
  logic [QUO_W-1:0]         dv_quot;
  logic [TAG_W-1:0]         dv_tag_raw;
  tag_t                     dv_tag;

  // candidate height
  logic [CHG_W-1:0]         change;
  logic signed [H_W:0]      z17, cand;
  logic signed [H_W-1:0]    cand_sat, z_e;
  logic                     keep_e;

  assign sqx_full = dxa_q * dxa_q;
  assign sqy_full = dya_q * dya_q;
  assign d2_sum   = D2_W'(sqxb_q) + D2_W'(sqyb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      va_q <= (state_q == ST_ISSUE);
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= sq_v;
      vf_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    dxa_q   <= $signed({1'b0, px_q}) - $signed({1'b0, sx_q});
    dya_q   <= $signed({1'b0, py_q}) - $signed({1'b0, sy_q});
    addra_q <= addr_q;
    lasta_q <= last_issue;

    sqxb_q  <= sqx_full[SQ_W-1:0];
    sqyb_q  <= sqy_full[SQ_W-1:0];
    zb_q    <= store_rdata;
    addrb_q <= addra_q;
    lastb_q <= lasta_q;

    // beyond 32 bits the distance already exceeds any radius
    d2c_q       <= d2_sum[RAD2_W-1:0];
    tagc_q.addr <= addrb_q;
    tagc_q.z    <= zb_q;
    tagc_q.skip <= |d2_sum[D2_W-1:RAD2_W];
    tagc_q.last <= lastb_q;

    // outside the radius the cone gives no positive change
    prodd_q <= PROD_W'(amount_q) * PROD_W'(sq_root);
    tagd_q  <= '{addr: sq_tag.addr, z: sq_tag.z,
                 skip: sq_tag.skip || (sq_root >= radius_q), last: sq_tag.last};

    af_q    <= cand_sat;
    keepf_q <= keep_e;
    addrf_q <= dv_tag.addr;
    lastf_q <= dv_tag.last;
  end

  hcb_sqrt #(
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vc_q),
    .value_i (d2c_q),
    .tag_i   (tagc_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .tag_o   (sq_tag_raw)
  );

  assign sq_tag = tag_t'(sq_tag_raw);

  hcb_div #(
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vd_q),
    .dividend_i (prodd_q),
    .divisor_i  (radius_q),
    .tag_i      (tagd_q),
    .valid_o    (dv_v),
    .quot_o     (dv_quot),
    .tag_o      (dv_tag_raw)
  );

  assign dv_tag = tag_t'(dv_tag_raw);

  always_comb begin
    z_e    = $signed(dv_tag.z);
    z17    = {z_e[H_W-1], z_e};
    change = {1'b0, amount_q} - {1'b0, dv_quot};
    cand   = lower_q ? (z17 - $signed({1'b0, change})) : (z17 + $signed({1'b0, change}));
    // saturate to 16 bits signed
    if (cand[H_W] != cand[H_W-1]) begin
      cand_sat = cand[H_W] ? {1'b1, {(H_W-1){1'b0}}} : {1'b0, {(H_W-1){1'b1}}};
    end else begin
      cand_sat = cand[H_W-1:0];
    end
    keep_e = !dv_tag.skip && (lower_q ? (cand_sat < z_e) : (cand_sat > z_e));
  end

  // tracked extremes follow each kept sample in walk order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= '0;
    end else if (vf_q && keepf_q) begin
      if (af_q > max_q) begin
        max_q <= af_q;
      end else if (af_q < min_q) begin
        min_q <= af_q;
      end
    end
  end

  // ---------------- result register ----------------
  logic signed [H_W-1:0] out_rd_q, out_max_q, out_min_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_rd_q  <= rd_val_q;
      out_max_q <= max_q;
      out_min_q <= min_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_value     = out_rd_q;
  assign out_o.highest_height = out_max_q;
  assign out_o.lowest_height  = out_min_q;

endmodule
`default_nettype wire

/* rtl/hcb_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_checker
// port-level checks of the cone brush unit
// ----------------------------------------------------------------------------
module hcb_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic signed [15:0]    read_value_i,
  input logic signed [15:0]    highest_i,
  input logic signed [15:0]    lowest_i
);

  // one command at a time: no second beat right after an accepted one
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted on consecutive cycles");

  // extremes start at zero and only spread outward
  a_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (highest_i >= 16'sd0) && (lowest_i <= 16'sd0))
    else $error("tracked extremes on wrong side of zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(read_value_i) && $stable(highest_i) && $stable(lowest_i))
    else $error("result beat changed while stalled");

endmodule

bind heightmap_cone_brush_unit hcb_checker u_hcb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .read_value_i (out_o.read_value),
  .highest_i    (out_o.highest_height),
  .lowest_i     (out_o.lowest_height)
);
`default_nettype wire
